### src/bse_pkg.sv
`default_nettype none
package bse_pkg;

    localparam int STATE_W      = 30;
    localparam int WORD_W       = 5;
    localparam int CHAR_W       = 7;
    localparam int ACC_W        = 12;
    localparam int PEND_W       = 4;
    localparam int CNT_W        = 3;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [STATE_W-1:0] HRP_RESET = 30'd1;
    localparam logic [CNT_W-1:0]   CHK_LAST  = 3'd5;   // sixth zero step / sixth checksum char
    localparam logic [PEND_W-1:0]  WORD_BITS = 4'd5;
    localparam logic [PEND_W-1:0]  BYTE_BITS = 4'd8;

    localparam logic [STATE_W-1:0] GEN [5] = '{
        30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
    };

    // one queue entry: a data word, or the request to finish the string
    typedef struct packed {
        logic              fin;
        logic [WORD_W-1:0] word;
    } t_cmd;

    typedef struct packed {
        logic               restart;
        logic [STATE_W-1:0] hrp;
    } t_cfg;

    typedef enum logic [1:0] {
        BK_FETCH,
        BK_CRUNCH,
        BK_EMIT
    } t_back_state;

    function automatic logic [STATE_W-1:0] poly_step(input logic [STATE_W-1:0] st,
                                                     input logic [WORD_W-1:0]  v);
        logic [STATE_W-1:0] nx;
        nx = {st[24:0], v};
        for (int j = 0; j < 5; j++) begin
            if (st[25+j]) begin
                nx = nx ^ GEN[j];
            end
        end
        return nx;
    endfunction

    function automatic logic [CHAR_W-1:0] bse_char(input logic [WORD_W-1:0] w);
        logic [CHAR_W-1:0] c;
        case (w)
            5'd0:  c = 7'h71;  // q
            5'd1:  c = 7'h70;  // p
            5'd2:  c = 7'h7a;  // z
            5'd3:  c = 7'h72;  // r
            5'd4:  c = 7'h79;  // y
            5'd5:  c = 7'h39;  // 9
            5'd6:  c = 7'h78;  // x
            5'd7:  c = 7'h38;  // 8
            5'd8:  c = 7'h67;  // g
            5'd9:  c = 7'h66;  // f
            5'd10: c = 7'h32;  // 2
            5'd11: c = 7'h74;  // t
            5'd12: c = 7'h76;  // v
            5'd13: c = 7'h64;  // d
            5'd14: c = 7'h77;  // w
            5'd15: c = 7'h30;  // 0
            5'd16: c = 7'h73;  // s
            5'd17: c = 7'h33;  // 3
            5'd18: c = 7'h6a;  // j
            5'd19: c = 7'h6e;  // n
            5'd20: c = 7'h35;  // 5
            5'd21: c = 7'h34;  // 4
            5'd22: c = 7'h6b;  // k
            5'd23: c = 7'h68;  // h
            5'd24: c = 7'h63;  // c
            5'd25: c = 7'h65;  // e
            5'd26: c = 7'h36;  // 6
            5'd27: c = 7'h6d;  // m
            5'd28: c = 7'h75;  // u
            5'd29: c = 7'h61;  // a
            5'd30: c = 7'h37;  // 7
            5'd31: c = 7'h6c;  // l
            default: c = 7'h71;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### src/bse_front.sv
`default_nettype none
module bse_front
    import bse_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    input  wire logic        i_full,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic [ACC_W-1:0]  r_acc,  n_acc;
    logic [PEND_W-1:0] r_pend, n_pend;
    logic              r_busy, n_busy;
    logic              r_last, n_last;
    logic [PEND_W-1:0] pend_left;

    assign o_ready   = !r_busy;
    assign pend_left = r_pend - WORD_BITS;

    always_comb begin
        n_acc  = r_acc;
        n_pend = r_pend;
        n_busy = r_busy;
        n_last = r_last;
        o_push = 1'b0;
        o_cmd  = '0;
        if (i_cfg.restart) begin
            n_acc  = '0;
            n_pend = '0;
            n_busy = 1'b0;
            n_last = 1'b0;
        end else if (!r_busy) begin
            if (i_valid) begin
                n_acc  = {r_acc[3:0], i_data_byte};
                n_pend = r_pend + BYTE_BITS;
                n_last = i_last_byte;
                n_busy = 1'b1;
            end
        end else if (!i_full) begin
            o_push = 1'b1;
            if (r_pend >= WORD_BITS) begin
                o_cmd.word = WORD_W'(r_acc >> pend_left);
                n_pend     = pend_left;
                if (pend_left < WORD_BITS && !r_last) begin
                    n_busy = 1'b0;
                end
            end else if (r_pend != '0) begin
                // partial word at end of string, zero padded on the right
                o_cmd.word = WORD_W'(r_acc << (WORD_BITS - r_pend));
                n_pend     = '0;
            end else begin
                o_cmd.fin = 1'b1;
                n_acc     = '0;
                n_busy    = 1'b0;
                n_last    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_pend <= '0;
            r_busy <= 1'b0;
            r_last <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_pend <= n_pend;
            r_busy <= n_busy;
            r_last <= n_last;
        end
    end

endmodule
`default_nettype wire

### src/bse_fifo.sv
`default_nettype none
module bse_fifo
    import bse_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_full,
    output logic      o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);

    t_cmd               r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_QW-1:0]  r_cnt;

    assign o_cmd   = r_mem[r_rd];
    assign o_full  = (r_cnt == CNT_QW'(DEPTH));
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_MAX) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_MAX) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### src/bse_back.sv
`default_nettype none
module bse_back
    import bse_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_cfg         i_cfg,
    input  wire t_cmd         i_cmd,
    input  wire logic         i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [CHAR_W-1:0] o_character,
    output logic [WORD_W-1:0] o_word_value,
    output logic              o_is_checksum,
    output logic              o_last_char
);

    t_back_state        r_st, n_st;
    logic [STATE_W-1:0] r_check, n_check;
    logic [STATE_W-1:0] r_mod, n_mod;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_ovalid, n_ovalid;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic [WORD_W-1:0]  r_word, n_word;
    logic               r_chk, n_chk;
    logic               r_lastc, n_lastc;
    logic               out_free;

    assign out_free      = !r_ovalid || i_ready;
    assign o_valid       = r_ovalid;
    assign o_character   = r_char;
    assign o_word_value  = r_word;
    assign o_is_checksum = r_chk;
    assign o_last_char   = r_lastc;

    always_comb begin
        n_st = r_st;
        if (i_cfg.restart) begin
            n_st = BK_FETCH;
        end else begin
            case (r_st)
                BK_FETCH: begin
                    if (!i_empty && i_cmd.fin) begin
                        n_st = BK_CRUNCH;
                    end
                end
                BK_CRUNCH: begin
                    if (r_cnt == CHK_LAST) begin
                        n_st = BK_EMIT;
                    end
                end
                BK_EMIT: begin
                    if (out_free && r_cnt == CHK_LAST) begin
                        n_st = BK_FETCH;
                    end
                end
                default: n_st = BK_FETCH;
            endcase
        end
    end

    always_comb begin
        o_pop    = 1'b0;
        n_check  = r_check;
        n_mod    = r_mod;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && !i_ready;
        n_word   = r_word;
        n_char   = r_char;
        n_chk    = r_chk;
        n_lastc  = r_lastc;
        if (i_cfg.restart) begin
            n_check  = i_cfg.hrp;
            n_cnt    = '0;
            n_ovalid = 1'b0;
        end else begin
            case (r_st)
                BK_FETCH: begin
                    if (!i_empty) begin
                        if (i_cmd.fin) begin
                            o_pop = 1'b1;
                            n_mod = r_check;
                            n_cnt = '0;
                        end else if (out_free) begin
                            o_pop    = 1'b1;
                            n_check  = poly_step(r_check, i_cmd.word);
                            n_ovalid = 1'b1;
                            n_word   = i_cmd.word;
                            n_char   = bse_char(i_cmd.word);
                            n_chk    = 1'b0;
                            n_lastc  = 1'b0;
                        end
                    end
                end
                BK_CRUNCH: begin
                    // six zero words; the final constant XOR rides on the last step
                    n_mod = poly_step(r_mod, '0) ^ STATE_W'(r_cnt == CHK_LAST);
                    n_cnt = (r_cnt == CHK_LAST) ? '0 : r_cnt + 1'b1;
                end
                BK_EMIT: begin
                    if (out_free) begin
                        n_ovalid = 1'b1;
                        n_word   = r_mod[STATE_W-1 -: WORD_W];
                        n_char   = bse_char(r_mod[STATE_W-1 -: WORD_W]);
                        n_chk    = 1'b1;
                        n_lastc  = (r_cnt == CHK_LAST);
                        n_mod    = {r_mod[STATE_W-WORD_W-1:0], {WORD_W{1'b0}}};
                        if (r_cnt == CHK_LAST) begin
                            n_cnt   = '0;
                            n_check = i_cfg.hrp;
                        end else begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= BK_FETCH;
            r_check  <= HRP_RESET;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_check  <= n_check;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mod   <= n_mod;
        r_word  <= n_word;
        r_char  <= n_char;
        r_chk   <= n_chk;
        r_lastc <= n_lastc;
    end

endmodule
`default_nettype wire

### src/bech32_stream_encoder_unit.sv
// Channel   Direction  Handshake          Beat payload
// input     in         i_valid/o_ready    i_data_byte, i_last_byte
// output    out        o_valid/i_ready    o_character, o_word_value, o_is_checksum, o_last_char
// config    in         APB psel/penable   hrp_check_state at byte address 0
//
// Front: a byte beat is taken only while idle; its one or two words go into the queue one
// word per cycle while the queue is not full; a last beat adds a pad word when bits are
// left, then the finish entry. Back: one data word per cycle while the queue holds one and
// the output is free; a finish is popped, then runs 6 zero polymod steps and 6 checksum chars.
// Reset is synchronous on i_rst_n; the check state loads 1.
// Either side stalls on its own; the queue holds QUEUE_DEPTH_P entries.
`default_nettype none
module bech32_stream_encoder_unit
    import bse_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [0:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [7:0]   i_data_byte,
    input  wire logic         i_last_byte,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [CHAR_W-1:0] o_character,
    output logic [WORD_W-1:0] o_word_value,
    output logic              o_is_checksum,
    output logic              o_last_char
);

    logic [STATE_W-1:0] r_hrp;
    logic               cfg_wr;
    t_cfg               cfg;
    t_cmd               push_cmd, head_cmd;
    logic               push, pop, full, empty;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr == 1'b0);
    assign prdata  = (paddr == 1'b0) ? {2'b00, r_hrp} : 32'd0;
    assign cfg.restart = cfg_wr;
    assign cfg.hrp     = cfg_wr ? pwdata[STATE_W-1:0] : r_hrp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hrp <= HRP_RESET;
        end else if (cfg_wr) begin
            r_hrp <= pwdata[STATE_W-1:0];
        end
    end

    bse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    bse_fifo #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    bse_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (head_cmd),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_character   (o_character),
        .o_word_value  (o_word_value),
        .o_is_checksum (o_is_checksum),
        .o_last_char   (o_last_char)
    );

endmodule
`default_nettype wire

### src/bse_checker.sv
`default_nettype none
module bse_checker
    import bse_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_valid,
    input wire logic              i_ready,
    input wire logic [CHAR_W-1:0] o_character,
    input wire logic [WORD_W-1:0] o_word_value,
    input wire logic              o_is_checksum,
    input wire logic              o_last_char
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_word_value) && $stable(o_character))
        else $error("output beat changed while stalled");

    a_last_is_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_char |-> o_is_checksum)
        else $error("last char outside checksum");

    // checksum chars stream without gaps once started
    a_chk_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_is_checksum && !o_last_char |=> o_valid && o_is_checksum)
        else $error("gap inside checksum");

    // a new string needs data words before its checksum
    a_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last_char |=> !o_valid || !o_is_checksum)
        else $error("checksum char right after end of string");

endmodule

bind bech32_stream_encoder_unit bse_checker u_bse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_character   (o_character),
    .o_word_value  (o_word_value),
    .o_is_checksum (o_is_checksum),
    .o_last_char   (o_last_char)
);
`default_nettype wire

### verif/tb_bech32_stream_encoder_unit.sv
`default_nettype none
module tb_bech32_stream_encoder_unit;
    import bse_pkg::*;

    localparam logic [0:0] HRP_ADDR    = 1'b0;
    localparam logic [0:0] UNUSED_ADDR = 1'b1;
    localparam int         SETTLE_CYC  = 24;
    localparam int         RANDOM_BYTES = 370;

    localparam logic [4:0][29:0] BCH_GEN = {
        30'h2a1462b3, 30'h3d4233dd, 30'h1ea119fa, 30'h26508e6d, 30'h3b6a57b2
    };
    localparam logic [8*32-1:0] SYMBOLS = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [WORD_W-1:0] val;
        logic              is_chk;
        logic              is_last;
    } t_char_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [0:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid;
    logic               o_ready;
    logic [7:0]         i_data_byte;
    logic               i_last_byte;
    logic               o_valid;
    logic               i_ready;
    logic [CHAR_W-1:0]  o_character;
    logic [WORD_W-1:0]  o_word_value;
    logic               o_is_checksum;
    logic               o_last_char;

    bech32_stream_encoder_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_character   (o_character),
        .o_word_value  (o_word_value),
        .o_is_checksum (o_is_checksum),
        .o_last_char   (o_last_char)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // encoder shadow state
    logic [29:0] hrp_shadow;
    logic [11:0] bit_acc;
    logic [3:0]  bit_cnt;
    logic [29:0] chk_state;

    t_char_beat pending_chars[$];
    int         mismatches = 0;
    int         bytes_sent = 0;
    int         rx_hold    = 0;
    bit         steady     = 1'b0;

    function automatic logic [29:0] polymod_step(input logic [29:0] st,
                                                 input logic [4:0]  v);
        logic [29:0] nx;
        nx = {st[24:0], v};
        for (int j = 0; j < 5; j++) begin
            if (st[25+j]) begin
                nx = nx ^ BCH_GEN[j];
            end
        end
        return nx;
    endfunction

    function automatic void emit_char(input logic [4:0] w, input logic c, input logic f);
        t_char_beat e;
        e.ch      = SYMBOLS[8*(31-w) +: 7];
        e.val     = w;
        e.is_chk  = c;
        e.is_last = f;
        pending_chars.push_back(e);
    endfunction

    function automatic void restart_string();
        bit_acc   = '0;
        bit_cnt   = '0;
        chk_state = hrp_shadow;
    endfunction

    function automatic void encode_byte(input logic [7:0] b, input logic l);
        logic [11:0] sh;
        logic [29:0] m;
        bit_acc = {bit_acc[3:0], b};
        bit_cnt = bit_cnt + 4'd8;
        while (bit_cnt >= 4'd5) begin
            bit_cnt   = bit_cnt - 4'd5;
            sh        = bit_acc >> bit_cnt;
            chk_state = polymod_step(chk_state, sh[4:0]);
            emit_char(sh[4:0], 1'b0, 1'b0);
        end
        if (l) begin
            if (bit_cnt != 4'd0) begin
                // pad the partial word with zeros on the right
                sh        = bit_acc << (4'd5 - bit_cnt);
                chk_state = polymod_step(chk_state, sh[4:0]);
                emit_char(sh[4:0], 1'b0, 1'b0);
            end
            m = chk_state;
            repeat (6) m = polymod_step(m, 5'd0);
            m = m ^ 30'd1;
            for (int i = 0; i < 6; i++) begin
                emit_char(m[5*(5-i) +: 5], 1'b1, i == 5);
            end
            restart_string();
        end
    endfunction

    // output side: random stalls, long hold on request, checks every beat
    initial begin : rx_side
        t_char_beat e;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_chars.size() == 0) begin
                    $error("unexpected beat: char %h value %0d", o_character, o_word_value);
                    mismatches++;
                end else begin
                    e = pending_chars.pop_front();
                    if (o_character !== e.ch) begin
                        $error("character: expected %h, got %h", e.ch, o_character);
                        mismatches++;
                    end
                    if (o_word_value !== e.val) begin
                        $error("word_value: expected %0d, got %0d", e.val, o_word_value);
                        mismatches++;
                    end
                    if (o_is_checksum !== e.is_chk) begin
                        $error("is_checksum: expected %b, got %b", e.is_chk, o_is_checksum);
                        mismatches++;
                    end
                    if (o_last_char !== e.is_last) begin
                        $error("last_char: expected %b, got %b", e.is_last, o_last_char);
                        mismatches++;
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold = rx_hold - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= steady || ($urandom_range(99) >= 6);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic l);
        if (!steady) begin
            while ($urandom_range(99) < 6) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= l;
        do @(posedge i_clk); while (!o_ready);
        encode_byte(b, l);
        bytes_sent++;
    endtask

    task automatic send_string(input int len, input bit terminate);
        for (int i = 0; i < len; i++) begin
            push_byte(8'($urandom_range(0, 255)), terminate && (i == len - 1));
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    // idle enough for a register access
    task automatic settle();
        drain();
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_hrp(input logic [0:0] a, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (a == HRP_ADDR) begin
            hrp_shadow = d[29:0];
            restart_string();
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_hrp();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= HRP_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {2'b00, hrp_shadow}) begin
            $error("hrp_check_state: expected %h, got %h", {2'b00, hrp_shadow}, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_single_byte();
        push_byte(8'h00, 1'b1);
        push_byte(8'hff, 1'b1);
        drain();
    endtask

    // lengths 2..5 leave 1, 4, 2, 0 bits for the pad word
    task automatic test_pad_lengths();
        for (int n = 2; n <= 5; n++) begin
            for (int i = 0; i < n; i++) begin
                push_byte((i % 2) ? 8'haa : ((n % 2) ? 8'hff : 8'h55), i == n - 1);
            end
        end
        drain();
    endtask

    task automatic test_config();
        settle();
        read_hrp();
        write_hrp(HRP_ADDR, 32'hffff_ffff);   // high bits beyond the register dropped
        read_hrp();
        push_byte(8'h80, 1'b1);
        settle();
        write_hrp(HRP_ADDR, 32'h0000_0000);
        read_hrp();
        push_byte(8'h01, 1'b1);
        settle();
        write_hrp(HRP_ADDR, 32'hc2a5_3c96);
        push_byte(8'h7e, 1'b1);
        settle();
    endtask

    // unused address mid-string is ignored; a real write drops the open string
    task automatic test_restart();
        push_byte(8'h3c, 1'b0);
        push_byte(8'hc3, 1'b0);
        settle();
        write_hrp(UNUSED_ADDR, 32'h1234_5678);
        read_hrp();
        push_byte(8'h5a, 1'b0);
        settle();
        write_hrp(HRP_ADDR, 32'h0000_0001);
        push_byte(8'hf0, 1'b1);
        drain();
    endtask

    task automatic test_backpressure();
        rx_hold = 300;
        send_string(20, 1'b1);
        send_string(33, 1'b1);
        drain();
    endtask

    task automatic test_random_strings();
        int start;
        int pick;
        int len;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            steady = (bytes_sent - start >= 120) && (bytes_sent - start < 230);
            pick   = $urandom_range(99);
            if (pick < 8) begin
                settle();
                write_hrp(HRP_ADDR, $urandom);
            end else if (pick < 11) begin
                send_string($urandom_range(1, 6), 1'b0);
                settle();
                write_hrp(HRP_ADDR, $urandom);
            end
            if (pick < 20) begin
                len = 33;
            end else if (pick < 24) begin
                len = $urandom_range(34, 60);
            end else begin
                len = $urandom_range(1, 8);
            end
            send_string(len, 1'b1);
        end
        steady = 1'b0;
        drain();
        settle();
        read_hrp();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= HRP_ADDR;
        pwdata      <= '0;
        i_valid     <= 1'b0;
        i_data_byte <= '0;
        i_last_byte <= 1'b0;
        hrp_shadow = 30'd1;
        restart_string();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_single_byte();
        test_pad_lengths();
        test_config();
        test_restart();
        test_backpressure();
        test_random_strings();

        drain();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire

### bech32_stream_encoder_unit.f
src/bse_pkg.sv
src/bse_front.sv
src/bse_fifo.sv
src/bse_back.sv
src/bech32_stream_encoder_unit.sv
src/bse_checker.sv
verif/tb_bech32_stream_encoder_unit.sv
